// ----- sv/cfth_pkg.sv -----
// Package for the CAN frame tracking hash table core.
// Holds status codes, command and status structs, and shared constants.
// Used by cfth_ctrl, cfth_dp and the top level; depends on nothing.
`default_nettype none
package cfth_pkg;

    // Table size; slot and count port widths are sized for 64 entries.
    localparam int unsigned TABLE_ENTRIES = 64;

    localparam logic [31:0] DIR_SEED = 32'h9E3779B9;
    localparam int unsigned MS_DIV = 1000;
    // Dividing a 32-bit value by 1000 is exact as (x * MS_RECIP) >> MS_SHIFT.
    localparam logic [28:0] MS_RECIP = 29'h10624DD3;
    localparam int unsigned MS_SHIFT = 38;
    localparam logic [3:0] MAX_LEN = 4'd8;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic claim;
        logic div_start;
        logic commit;
        logic drop;
    } t_cmd;

    typedef struct packed {
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/cfth_ctrl.sv -----
// Controller state machine for the CAN frame tracking hash table core.
// Sequences probe reads, the period divider and the entry write-back.
// Depends on cfth_pkg.
`default_nettype none
module cfth_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire cfth_pkg::t_stat i_stat,
    output cfth_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CHECK, S_DIV, S_DONE} t_state;
    t_state r_state;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_start;
            S_READ:  o_cmd.rd = 1'b1;
            S_CHECK: begin
                if (!i_stat.slot_valid) begin
                    o_cmd.claim = 1'b1;
                    o_cmd.div_start = 1'b1;
                end else if (i_stat.key_match) begin
                    o_cmd.div_start = 1'b1;
                end else if (i_stat.last_probe) begin
                    o_cmd.drop = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DIV:   o_cmd.commit = i_stat.div_done;
            S_DONE:  o_cmd = '0;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (i_start) r_state <= S_READ;
                S_READ:  r_state <= S_CHECK;
                S_CHECK: begin
                    if (!i_stat.slot_valid || i_stat.key_match) r_state <= S_DIV;
                    else if (i_stat.last_probe) r_state <= S_DONE;
                    else r_state <= S_READ;
                end
                S_DIV:   if (i_stat.div_done) r_state <= S_DONE;
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_commit_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> r_state == S_DIV)
        else $error("commit outside divide state");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("done not followed by idle");
    a_drop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drop |=> r_state == S_DONE)
        else $error("drop did not finish");

endmodule
`default_nettype wire

// ----- sv/cfth_dp.sv -----
// Datapath of the CAN frame tracking hash table core: frame register,
// slot memory, valid bits, probe pointer, reciprocal period unit and result regs.
// Depends on cfth_pkg.
`default_nettype none
module cfth_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire cfth_pkg::t_cmd i_cmd,
    output cfth_pkg::t_stat   o_stat,
    input  wire [28:0]        i_can_id,
    input  wire               i_direction,
    input  wire [3:0]         i_length_code,
    input  wire [63:0]        i_payload,
    input  wire [31:0]        i_timestamp_us,
    input  wire               i_mutated_flag,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [5:0]        o_slot,
    output logic [22:0]       o_period_ms,
    output logic [7:0]        o_changed_mask,
    output logic [3:0]        o_stored_length,
    output logic [6:0]        o_entry_count
);

    localparam int unsigned ENTRIES = cfth_pkg::TABLE_ENTRIES;
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned PTRW = AW + 1;

    // Entry layout: ident, dir, len, bytes, altered, last_time, period, change.
    typedef struct packed {
        logic [28:0] ident;
        logic        dir;
        logic [3:0]  len;
        logic [63:0] bytes;
        logic        altered;
        logic [31:0] last_time;
        logic [21:0] period;
        logic [7:0]  change;
    } t_entry;

    t_entry r_mem [ENTRIES];
    t_entry r_rd;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0] r_count;

    logic [28:0] r_id;
    logic        r_dir;
    logic [3:0]  r_len;
    logic [63:0] r_data;
    logic [31:0] r_now;
    logic        r_alt;
    logic [AW-1:0] r_ptr;
    logic [PTRW-1:0] r_probes;
    logic        r_new;

    // Merged entry state held while the period is computed.
    logic [63:0] r_bytes;
    logic [7:0]  r_mask;
    logic        r_has_prev;

    // Period: registered time difference, then a registered reciprocal multiply.
    logic [31:0] r_diff;
    logic [22:0] r_quo;
    logic        r_qvalid;
    logic        r_dbusy;

    logic [31:0] seed, hsh;
    logic [AW-1:0] home;
    logic [31:0] prev;
    logic [63:0] n_bytes;
    logic [7:0]  n_mask;
    logic [60:0] prod;

    always_comb begin
        seed = {3'b000, i_can_id} ^ (i_direction ? cfth_pkg::DIR_SEED : 32'd0);
        hsh  = seed ^ (seed >> 16);
        home = AW'(hsh % ENTRIES);
    end

    always_comb begin
        t_entry src;
        src = r_rd;
        if (!o_stat.slot_valid) begin
            src = '0;
        end
        prev = src.last_time;
        n_bytes = src.bytes;
        n_mask = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < r_len && src.bytes[8*i +: 8] != r_data[8*i +: 8]) begin
                n_mask[i] = 1'b1;
                n_bytes[8*i +: 8] = r_data[8*i +: 8];
            end
        end
    end

    assign o_stat.slot_valid = r_valid[r_ptr];
    assign o_stat.key_match  = (r_rd.ident == r_id) && (r_rd.dir == r_dir);
    assign o_stat.last_probe = (r_probes == PTRW'(ENTRIES - 1));
    assign o_stat.div_done   = r_dbusy && r_qvalid;

    assign prod = {29'd0, r_diff} * {32'd0, cfth_pkg::MS_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id     <= i_can_id;
            r_dir    <= i_direction;
            r_len    <= (i_length_code > cfth_pkg::MAX_LEN) ? cfth_pkg::MAX_LEN
                                                            : i_length_code;
            r_data   <= i_payload;
            r_now    <= i_timestamp_us;
            r_alt    <= i_mutated_flag;
            r_ptr    <= home;
            r_probes <= '0;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_ptr];
        end
        if (i_cmd.step) begin
            r_ptr    <= (r_ptr == AW'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_new      <= i_cmd.claim;
            r_bytes    <= n_bytes;
            r_mask     <= n_mask;
            r_has_prev <= (prev != 32'd0);
            r_diff     <= r_now - prev;
            r_qvalid   <= 1'b0;
        end else if (r_dbusy && !r_qvalid) begin
            r_quo    <= 23'(prod >> cfth_pkg::MS_SHIFT);
            r_qvalid <= 1'b1;
        end
        if (i_cmd.commit) begin
            r_mem[r_ptr] <= '{ident: r_id, dir: r_dir, len: r_len, bytes: r_bytes,
                              altered: r_alt, last_time: r_now,
                              period: r_has_prev ? r_quo[21:0] : 22'd0,
                              change: r_has_prev ? r_mask : 8'd0};
        end
        if (i_cmd.commit) begin
            o_status        <= r_new ? cfth_pkg::ST_CREATED : cfth_pkg::ST_UPDATED;
            o_slot          <= 6'(r_ptr);
            o_period_ms     <= r_has_prev ? r_quo : 23'd0;
            o_changed_mask  <= r_has_prev ? r_mask : 8'd0;
            o_stored_length <= r_len;
            o_entry_count   <= 7'(r_count + CW'(r_new));
        end else if (i_cmd.drop) begin
            o_status        <= cfth_pkg::ST_DROPPED;
            o_slot          <= '0;
            o_period_ms     <= '0;
            o_changed_mask  <= '0;
            o_stored_length <= '0;
            o_entry_count   <= 7'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_dbusy <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.commit || i_cmd.drop;
            if (i_cmd.div_start) r_dbusy <= 1'b1;
            else if (o_stat.div_done) r_dbusy <= 1'b0;
            if (i_cmd.commit && r_new) begin
                r_valid[r_ptr] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count overflow");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("entry count disagrees with valid bits");
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_new |-> !r_valid[r_ptr])
        else $error("claim of an occupied slot");

endmodule
`default_nettype wire

// ----- sv/can_frame_tracking_hash_table_core.sv -----
// CAN frame tracking hash table core: each probed slot is read, then checked; the period
// is a registered difference, then a reciprocal multiply, and the result strobe follows
// on a hit or claim; a drop strobes after the full 64-slot walk.
// Busy stays high through the strobe, so a new frame is taken only after it.
// Reset is synchronous, active low: valid bits and count clear at once; no stall.
`default_nettype none
module can_frame_tracking_hash_table_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [28:0] i_can_id,
    input  wire         i_direction,
    input  wire  [3:0]  i_length_code,
    input  wire  [63:0] i_payload,
    input  wire  [31:0] i_timestamp_us,
    input  wire         i_mutated_flag,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [22:0] o_period_ms,
    output logic [7:0]  o_changed_mask,
    output logic [3:0]  o_stored_length,
    output logic [6:0]  o_entry_count
);

    // Commands flow from the controller to the datapath; status flows back.
    cfth_pkg::t_cmd  cmd;
    cfth_pkg::t_stat stat;

    // The controller only sees start while idle, so a transfer is start and !busy.
    cfth_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cfth_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_can_id        (i_can_id),
        .i_direction     (i_direction),
        .i_length_code   (i_length_code),
        .i_payload       (i_payload),
        .i_timestamp_us  (i_timestamp_us),
        .i_mutated_flag  (i_mutated_flag),
        .o_done          (o_valid),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_period_ms     (o_period_ms),
        .o_changed_mask  (o_changed_mask),
        .o_stored_length (o_stored_length),
        .o_entry_count   (o_entry_count)
    );

endmodule
`default_nettype wire
